[src/lav_pkg.sv]
// Shared types and widths for the look-at view matrix block.
// Depends on nothing; every other file of the block imports it.
`default_nettype none
package lav_pkg;

    localparam logic [1:0] ROW_LAST = 2'd2;

    // One accepted item, with eye minus target already formed.
    typedef struct packed {
        logic [2:0][31:0] eye;
        logic [2:0][32:0] dif;
        logic [2:0][31:0] up;
    } t_item;

    // The finished matrix: cols[row][column], plus the degenerate flag.
    typedef struct packed {
        logic [2:0][3:0][31:0] cols;
        logic                  deg;
    } t_result;

endpackage
`default_nettype wire

[src/lav_front.sv]
// Input side of the look-at block: a two-entry queue of accepted items.
// Depends on lav_pkg for the item type.
`default_nettype none
module lav_front (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_valid,
    output logic                o_stall,
    input  wire  [31:0]         i_eye_x,
    input  wire  [31:0]         i_eye_y,
    input  wire  [31:0]         i_eye_z,
    input  wire  [31:0]         i_target_x,
    input  wire  [31:0]         i_target_y,
    input  wire  [31:0]         i_target_z,
    input  wire  [31:0]         i_up_x,
    input  wire  [31:0]         i_up_y,
    input  wire  [31:0]         i_up_z,
    output logic                o_q_valid,
    output lav_pkg::t_item      o_q_item,
    input  wire                 i_q_pop
);
    import lav_pkg::*;

    t_item      r_mem [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;
    t_item      w_new;
    logic       w_push;

    // Eye minus target is formed on entry, one bit wider so it never wraps.
    always_comb begin
        w_new.eye = {i_eye_z, i_eye_y, i_eye_x};
        w_new.up  = {i_up_z, i_up_y, i_up_x};
        w_new.dif[0] = {i_eye_x[31], i_eye_x} - {i_target_x[31], i_target_x};
        w_new.dif[1] = {i_eye_y[31], i_eye_y} - {i_target_y[31], i_target_y};
        w_new.dif[2] = {i_eye_z[31], i_eye_z} - {i_target_z[31], i_target_z};
    end

    assign o_stall   = (r_cnt == 2'd2);
    assign w_push    = i_valid && !o_stall;
    assign o_q_valid = (r_cnt != 2'd0);
    assign o_q_item  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wp] <= w_new;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_push) begin
                r_wp <= !r_wp;
            end
            if (i_q_pop) begin
                r_rp <= !r_rp;
            end
            r_cnt <= r_cnt + {1'b0, w_push} - {1'b0, i_q_pop};
        end
    end

endmodule
`default_nettype wire

[src/lav_back.sv]
// Arithmetic engine of the look-at block: normalize, cross and dot products
// on one shared multiplier, bit-serial square root and divider. Uses lav_pkg.
`default_nettype none
module lav_back (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_q_valid,
    input  lav_pkg::t_item      i_q_item,
    output logic                o_q_pop,
    input  wire                 i_out_busy,
    output logic                o_load,
    output lav_pkg::t_result    o_res
);
    import lav_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE, S_NCHK, S_NSHIFT, S_SQ, S_SQRT, S_DIVP, S_DIV, S_CROSS, S_DOT, S_DONE
    } t_state;

    t_state                  r_state;
    logic [2:0][31:0]        r_eye;
    logic [2:0][31:0]        r_up;
    logic [2:0][51:0]        r_m;
    logic [2:0]              r_s;
    logic                    r_pass;
    logic [2:0][17:0]        r_z;
    logic [2:0][17:0]        r_x;
    logic [2:0][19:0]        r_y;
    logic [2:0][31:0]        r_t;
    logic                    r_deg;
    logic [4:0]              r_step;
    logic [1:0]              r_i;
    logic [1:0]              r_r;
    logic signed [52:0]      r_prod;
    logic signed [53:0]      r_acc;
    logic [59:0]             r_sqp;
    logic [61:0]             r_sum;
    logic [61:0]             r_rem;
    logic [62:0]             r_res;
    logic [62:0]             r_bit;
    logic [46:0]             r_remd;
    logic [47:0]             r_dvs;
    logic [16:0]             r_q;

    logic [1:0]              w_ui;
    logic [1:0]              w_wi;
    logic [1:0]              w_ti;
    logic signed [32:0]      w_ma;
    logic signed [19:0]      w_mb;
    logic signed [52:0]      w_prod;
    logic [29:0]             w_sqa;
    logic signed [53:0]      w_pext;
    logic signed [53:0]      w_diff;
    logic signed [53:0]      w_dsum;
    logic [53:0]             w_dmag;
    logic [63:0]             w_trial;
    logic [16:0]             w_qn;
    logic [17:0]             w_qs;
    logic signed [39:0]      w_rd;
    logic signed [39:0]      w_ry;
    logic signed [39:0]      w_tn;
    logic [31:0]             w_tsat;
    logic                    w_hi;
    logic                    w_in29;
    logic                    w_zero;

    // Round a Q32.32 value to Q16.16, half away from zero.
    function automatic logic signed [39:0] round16(input logic signed [53:0] v);
        logic [53:0] mag;
        logic [53:0] rm;
        mag = v[53] ? 54'(-v) : 54'(v);
        rm  = (mag + 54'd32768) >> 16;
        return v[53] ? -$signed({2'b00, rm[37:0]}) : $signed({2'b00, rm[37:0]});
    endfunction

    // Operand indexes of the cross product schedule u x w.
    always_comb begin
        case (r_step[2:0])
            3'd0: begin w_ui = 2'd1; w_wi = 2'd2; end
            3'd1: begin w_ui = 2'd2; w_wi = 2'd1; end
            3'd2: begin w_ui = 2'd2; w_wi = 2'd0; end
            3'd3: begin w_ui = 2'd0; w_wi = 2'd2; end
            3'd4: begin w_ui = 2'd0; w_wi = 2'd1; end
            3'd5: begin w_ui = 2'd1; w_wi = 2'd0; end
            default: begin w_ui = 2'd0; w_wi = 2'd0; end
        endcase
        w_ti = (r_step[1:0] == 2'd3) ? 2'd0 : r_step[1:0];
    end

    always_comb begin
        w_ma = '0;
        w_mb = '0;
        case (r_state)
            S_CROSS: begin
                if (r_pass) begin
                    w_ma = {{15{r_z[w_ui][17]}}, r_z[w_ui]};
                    w_mb = {{2{r_x[w_wi][17]}}, r_x[w_wi]};
                end else begin
                    w_ma = {r_up[w_ui][31], r_up[w_ui]};
                    w_mb = {{2{r_z[w_wi][17]}}, r_z[w_wi]};
                end
            end
            S_DOT: begin
                w_ma = {r_eye[w_ti][31], r_eye[w_ti]};
                case (r_r)
                    2'd0:    w_mb = {{2{r_x[w_ti][17]}}, r_x[w_ti]};
                    2'd1:    w_mb = r_y[w_ti];
                    default: w_mb = {{2{r_z[w_ti][17]}}, r_z[w_ti]};
                endcase
            end
            default: begin
                w_ma = '0;
                w_mb = '0;
            end
        endcase
    end

    assign w_prod = w_ma * w_mb;
    assign w_sqa  = r_m[w_ti][29:0];
    assign w_pext = {r_prod[52], r_prod};
    assign w_diff = r_acc - w_pext;
    assign w_dsum = r_acc + w_pext;
    assign w_dmag = w_diff[53] ? 54'(-w_diff) : 54'(w_diff);
    assign w_ry   = round16(w_diff);
    assign w_rd   = round16(w_dsum);
    assign w_tn   = -w_rd;
    assign w_tsat = (w_tn > 40'sd2147483647)  ? 32'h7FFF_FFFF :
                    (w_tn < -40'sd2147483648) ? 32'h8000_0000 : w_tn[31:0];
    assign w_trial = {1'b0, r_res} + {1'b0, r_bit};
    assign w_qn    = ({1'b0, r_remd} >= r_dvs) ? {r_q[15:0], 1'b1} : {r_q[15:0], 1'b0};
    assign w_qs    = r_s[r_i] ? 18'(-{1'b0, w_qn}) : {1'b0, w_qn};
    assign w_hi    = |{r_m[0][51:30], r_m[1][51:30], r_m[2][51:30]};
    assign w_in29  = r_m[0][29] | r_m[1][29] | r_m[2][29];
    assign w_zero  = (r_m[0] == '0) && (r_m[1] == '0) && (r_m[2] == '0);

    assign o_q_pop = (r_state == S_IDLE) && i_q_valid;
    assign o_load  = (r_state == S_DONE) && !i_out_busy;

    always_comb begin
        o_res.deg = r_deg;
        if (r_deg) begin
            o_res.cols = '0;
        end else begin
            o_res.cols[0] = {r_t[0], {{14{r_x[2][17]}}, r_x[2]},
                             {{14{r_x[1][17]}}, r_x[1]}, {{14{r_x[0][17]}}, r_x[0]}};
            o_res.cols[1] = {r_t[1], {{12{r_y[2][19]}}, r_y[2]},
                             {{12{r_y[1][19]}}, r_y[1]}, {{12{r_y[0][19]}}, r_y[0]}};
            o_res.cols[2] = {r_t[2], {{14{r_z[2][17]}}, r_z[2]},
                             {{14{r_z[1][17]}}, r_z[1]}, {{14{r_z[0][17]}}, r_z[0]}};
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod <= w_prod;
        r_sqp  <= w_sqa * w_sqa;
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (i_q_valid) begin
                        r_eye  <= i_q_item.eye;
                        r_up   <= i_q_item.up;
                        r_deg  <= 1'b0;
                        r_pass <= 1'b0;
                        for (int k = 0; k < 3; k++) begin
                            // Negate at 33 bits so the magnitude is taken before widening.
                            r_s[k] <= i_q_item.dif[k][32];
                            r_m[k] <= i_q_item.dif[k][32] ?
                                      52'(33'(-i_q_item.dif[k])) : 52'(i_q_item.dif[k]);
                        end
                        r_state <= S_NCHK;
                    end
                end
                S_NCHK: begin
                    if (w_zero) begin
                        r_deg   <= 1'b1;
                        r_state <= S_DONE;
                    end else begin
                        r_state <= S_NSHIFT;
                    end
                end
                S_NSHIFT: begin
                    // Walk the largest magnitude into [2^29, 2^30) one bit a cycle.
                    if (w_hi) begin
                        for (int k = 0; k < 3; k++) r_m[k] <= r_m[k] >> 1;
                    end else if (!w_in29) begin
                        for (int k = 0; k < 3; k++) r_m[k] <= r_m[k] << 1;
                    end else begin
                        r_step  <= '0;
                        r_state <= S_SQ;
                    end
                end
                S_SQ: begin
                    r_step <= r_step + 5'd1;
                    if (r_step == 5'd1) begin
                        r_sum <= {2'b00, r_sqp};
                    end else if (r_step == 5'd2) begin
                        r_sum <= r_sum + {2'b00, r_sqp};
                    end else if (r_step == 5'd3) begin
                        r_rem   <= r_sum + {2'b00, r_sqp};
                        r_res   <= '0;
                        r_bit   <= {1'b1, 62'd0} >> 0;
                        r_step  <= '0;
                        r_state <= S_SQRT;
                    end
                end
                S_SQRT: begin
                    if ({2'b00, r_rem} >= w_trial) begin
                        r_rem <= r_rem - w_trial[61:0];
                        r_res <= (r_res >> 1) + r_bit;
                    end else begin
                        r_res <= r_res >> 1;
                    end
                    r_bit  <= r_bit >> 2;
                    r_step <= r_step + 5'd1;
                    if (r_step == 5'd31) begin
                        r_i     <= 2'd0;
                        r_state <= S_DIVP;
                    end
                end
                S_DIVP: begin
                    r_remd  <= {1'b0, r_m[r_i][29:0], 16'd0} + 47'(r_res[30:1]);
                    r_dvs   <= {r_res[30:0], 17'd0};
                    r_q     <= '0;
                    r_step  <= '0;
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    // Restoring division, one quotient bit a cycle.
                    if ({1'b0, r_remd} >= r_dvs) begin
                        r_remd <= r_remd - r_dvs[46:0];
                    end
                    r_q    <= w_qn;
                    r_dvs  <= r_dvs >> 1;
                    r_step <= r_step + 5'd1;
                    if (r_step == 5'd17) begin
                        if (r_pass) begin
                            r_x[r_i] <= w_qs;
                        end else begin
                            r_z[r_i] <= w_qs;
                        end
                        if (r_i == 2'd2) begin
                            r_step  <= '0;
                            r_state <= S_CROSS;
                        end else begin
                            r_i     <= r_i + 2'd1;
                            r_state <= S_DIVP;
                        end
                    end
                end
                S_CROSS: begin
                    r_step <= r_step + 5'd1;
                    if (r_step != 5'd0) begin
                        if (r_step[0]) begin
                            r_acc <= w_pext;
                        end else if (r_pass) begin
                            r_y[r_step[2:1] - 2'd1] <= w_ry[19:0];
                        end else begin
                            r_m[r_step[2:1] - 2'd1] <= w_dmag[51:0];
                            r_s[r_step[2:1] - 2'd1] <= w_diff[53];
                        end
                    end
                    if (r_step == 5'd6) begin
                        r_step <= '0;
                        if (r_pass) begin
                            r_r     <= 2'd0;
                            r_state <= S_DOT;
                        end else begin
                            r_pass  <= 1'b1;
                            r_state <= S_NCHK;
                        end
                    end
                end
                S_DOT: begin
                    r_step <= r_step + 5'd1;
                    if (r_step == 5'd1) begin
                        r_acc <= w_pext;
                    end else if (r_step == 5'd2) begin
                        r_acc <= w_dsum;
                    end else if (r_step == 5'd3) begin
                        r_t[r_r] <= w_tsat;
                        r_step   <= '0;
                        if (r_r == ROW_LAST) begin
                            r_state <= S_DONE;
                        end else begin
                            r_r <= r_r + 2'd1;
                        end
                    end
                end
                S_DONE: begin
                    if (!i_out_busy) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule
`default_nettype wire

[src/lav_rows.sv]
// Output side of the look-at block: holds one finished matrix and sends
// its three rows in order. Depends on lav_pkg for the result type.
`default_nettype none
module lav_rows (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_load,
    input  lav_pkg::t_result    i_res,
    output logic                o_busy,
    output logic                o_valid,
    input  wire                 i_stall,
    output logic [1:0]          o_row_index,
    output logic [31:0]         o_col0,
    output logic [31:0]         o_col1,
    output logic [31:0]         o_col2,
    output logic [31:0]         o_col3,
    output logic                o_last_row,
    output logic                o_degenerate
);
    import lav_pkg::*;

    logic       r_busy;
    logic [1:0] r_row;
    t_result    r_res;
    logic [3:0][31:0] w_cols;

    always_comb begin
        case (r_row)
            2'd0:    w_cols = r_res.cols[0];
            2'd1:    w_cols = r_res.cols[1];
            default: w_cols = r_res.cols[2];
        endcase
    end

    assign o_busy       = r_busy;
    assign o_valid      = r_busy;
    assign o_row_index  = r_row;
    assign o_col0       = w_cols[0];
    assign o_col1       = w_cols[1];
    assign o_col2       = w_cols[2];
    assign o_col3       = w_cols[3];
    assign o_last_row   = (r_row == ROW_LAST);
    assign o_degenerate = r_res.deg;

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_res <= i_res;
        end
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_row  <= 2'd0;
        end else if (i_load) begin
            r_busy <= 1'b1;
            r_row  <= 2'd0;
        end else if (r_busy && !i_stall) begin
            if (r_row == ROW_LAST) begin
                r_busy <= 1'b0;
                r_row  <= 2'd0;
            end else begin
                r_row <= r_row + 2'd1;
            end
        end
    end

    a_deg_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_degenerate |->
            o_col0 == 32'd0 && o_col1 == 32'd0 && o_col2 == 32'd0 && o_col3 == 32'd0)
        else $error("degenerate row carries nonzero columns");

    a_row_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_stall && r_row != ROW_LAST |=>
            o_valid && r_row == $past(r_row) + 2'd1)
        else $error("row sequence broken");

    a_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_load |-> !r_busy)
        else $error("matrix loaded over one still being sent");

endmodule
`default_nettype wire

[src/look_at_view_matrix_top.sv]
// Top level of the look-at view matrix block.
// Instantiates lav_front, lav_back and lav_rows; uses lav_pkg.
`default_nettype none
// Each input transfer carries an eye point, a target point and a world-up
// vector in signed Q16.16; for it the block sends three output transfers,
// rows 0, 1 and 2 of the view matrix (camera x, y and z axes, each with its
// saturated translation in col3), with last_row marking row 2. When eye
// equals target, or up is zero or parallel to the view direction, all three
// rows still come out but their columns are zero and degenerate is set.
// A two-entry input queue takes items while the engine works, and a held
// result goes out row by row while the engine starts on the next item. The
// engine handles one item at a time and, once done, waits for the row
// sender to free up. The two normalizations dominate its work, each with a
// one-bit-per-cycle alignment shift, a sum of squares, a 32-step square
// root and three 18-step divisions with a setup state each; the cross and
// dot products then run on one shared multiplier.
module look_at_view_matrix_top (
    input  wire          i_clk,
    input  wire          i_rst_n,
    input  wire          i_valid,
    output logic         o_stall,
    input  wire  [31:0]  i_eye_x,
    input  wire  [31:0]  i_eye_y,
    input  wire  [31:0]  i_eye_z,
    input  wire  [31:0]  i_target_x,
    input  wire  [31:0]  i_target_y,
    input  wire  [31:0]  i_target_z,
    input  wire  [31:0]  i_up_x,
    input  wire  [31:0]  i_up_y,
    input  wire  [31:0]  i_up_z,
    output logic         o_valid,
    input  wire          i_stall,
    output logic [1:0]   o_row_index,
    output logic [31:0]  o_col0,
    output logic [31:0]  o_col1,
    output logic [31:0]  o_col2,
    output logic [31:0]  o_col3,
    output logic         o_last_row,
    output logic         o_degenerate
);
    import lav_pkg::*;

    logic    w_q_valid;
    t_item   w_q_item;
    logic    w_q_pop;
    logic    w_busy;
    logic    w_load;
    t_result w_res;

    // Queue of accepted transfers, with eye minus target formed on entry.
    lav_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_stall    (o_stall),
        .i_eye_x    (i_eye_x),
        .i_eye_y    (i_eye_y),
        .i_eye_z    (i_eye_z),
        .i_target_x (i_target_x),
        .i_target_y (i_target_y),
        .i_target_z (i_target_z),
        .i_up_x     (i_up_x),
        .i_up_y     (i_up_y),
        .i_up_z     (i_up_z),
        .o_q_valid  (w_q_valid),
        .o_q_item   (w_q_item),
        .i_q_pop    (w_q_pop)
    );

    // Arithmetic engine: both normalizations, cross and dot products.
    lav_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_q_valid  (w_q_valid),
        .i_q_item   (w_q_item),
        .o_q_pop    (w_q_pop),
        .i_out_busy (w_busy),
        .o_load     (w_load),
        .o_res      (w_res)
    );

    // Row sender: one output transfer per matrix row.
    lav_rows u_rows (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_load       (w_load),
        .i_res        (w_res),
        .o_busy       (w_busy),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_row_index  (o_row_index),
        .o_col0       (o_col0),
        .o_col1       (o_col1),
        .o_col2       (o_col2),
        .o_col3       (o_col3),
        .o_last_row   (o_last_row),
        .o_degenerate (o_degenerate)
    );

endmodule
`default_nettype wire
